FILE: hw/rtl/fnv1a_key_partitioner_top_macros.svh
// Assertion macros for the FNV-1a key partitioner.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FNV1A_KEY_PARTITIONER_TOP_MACROS_SVH
`define FNV1A_KEY_PARTITIONER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FKP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FKP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fkp_pkg.sv
// Package for the FNV-1a key partitioner: field types, hash constants and
// the per-byte hash step. No dependencies.
package fkp_pkg;

    localparam int HASH_W   = 64;
    localparam int BUCKET_W = 16;
    localparam int BYTE_W   = 8;

    typedef logic [HASH_W-1:0]   hash_t;
    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [BYTE_W-1:0]   byte_t;

    localparam hash_t   FNV_BASIS     = 64'hcbf2_9ce4_8422_2325;
    localparam hash_t   HASH_MULT     = 64'h0000_0100_0000_01b3;
    localparam bucket_t BUCKET_CNT_RST = 16'd1;

    // One FNV-1a byte step: xor the byte in, multiply by the prime mod 2^64.
    // The prime is 2^40 + 0x1b3, so the product is a sparse shift-add.
    function automatic hash_t fnv_mix(input hash_t h, input byte_t b);
        hash_t x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5)
             + (x << 4) + (x << 1) + x;
    endfunction

endpackage

FILE: hw/rtl/fkp_if.sv
// Valid/ready channel interfaces for key bytes in and hash results out.
// Depends on fkp_pkg for the field types.
interface fkp_in_if;
    import fkp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t key_byte;
    logic  byte_present;
    logic  key_end;

    modport source (output valid, key_byte, byte_present, key_end, input ready);
    modport sink   (input valid, key_byte, byte_present, key_end, output ready);
endinterface

interface fkp_out_if;
    import fkp_pkg::*;

    logic    valid;
    logic    ready;
    bucket_t bucket;
    hash_t   hash_value;

    modport source (output valid, bucket, hash_value, input ready);
    modport sink   (input valid, bucket, hash_value, output ready);
endinterface

FILE: hw/rtl/fnv1a_key_partitioner_top.sv
// FNV-1a key partitioner: running 64-bit hash per key, bucket = hash mod count (0 when count is 0).
// Depends on fkp_pkg, fkp_if.sv and fnv1a_key_partitioner_top_macros.svh.
//
//  channel    dir   handshake        word
//  key_in     in    valid/ready      key_byte, byte_present, key_end
//  hash_out   out   valid/ready      bucket, hash_value
//  cfg        in    cfg_wr_en        cfg_wr_data = bucket_count
//
// A word without the end mark takes one shift-add hash step if byte_present
// is set, else it is ignored; key_in.ready stays high. A word with the end
// mark drops key_in.ready once taken, for the 64 steps of the bit-serial
// restoring divider and the output load, which waits on a held result.
// Reset (rst_n low, async) puts the hash at the offset basis, bucket_count
// at 1 and drops hash_out.valid. While a result waits in the output
// register, bytes are still taken; a finished key waits for it to drain.
`include "fnv1a_key_partitioner_top_macros.svh"

module fnv1a_key_partitioner_top (
    input  logic             clk,
    input  logic             rst_n,
    fkp_in_if.sink           key_in,
    fkp_out_if.source        hash_out,
    input  logic             cfg_wr_en,
    input  fkp_pkg::bucket_t cfg_wr_data
);
    import fkp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int ITER_W = $clog2(HASH_W);

    logic [1:0]        state_reg, state_next;
    hash_t             hash_reg, hash_next;
    hash_t             work_reg, work_next;
    bucket_t           rem_reg, rem_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    bucket_t           bcount_reg;
    logic              out_valid_reg, out_valid_next;
    bucket_t           out_bucket_reg;
    hash_t             out_hash_reg;

    logic              in_acc;
    logic              out_load;
    hash_t             mixed;
    hash_t             final_hash;
    logic [BUCKET_W:0] rem_shift;
    logic [BUCKET_W+1:0] rem_diff;

    assign key_in.ready = (state_reg == ST_IDLE);
    assign in_acc       = key_in.valid && key_in.ready;

    // Byte step and the hash that closes the key
    assign mixed      = fnv_mix(hash_reg, key_in.key_byte);
    assign final_hash = key_in.byte_present ? mixed : hash_reg;

    // Divider step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, work_reg[HASH_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, bcount_reg};

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || hash_out.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (key_in.key_end)
                    begin
                        hash_next  = FNV_BASIS;
                        work_next  = final_hash;
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ST_DIV;
                    end
                    else if (key_in.byte_present)
                    begin
                        hash_next = mixed;
                    end
                end
            end
            ST_DIV:
            begin
                // rotate so the hash is whole again after the last step
                work_next = {work_reg[HASH_W-2:0], work_reg[HASH_W-1]};
                rem_next  = rem_diff[BUCKET_W+1] ? rem_shift[BUCKET_W-1:0]
                                                 : rem_diff[BUCKET_W-1:0];
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(HASH_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (hash_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FNV_BASIS;
            bcount_reg    <= BUCKET_CNT_RST;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            if (cfg_wr_en)
            begin
                bcount_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (out_load)
        begin
            out_bucket_reg <= (bcount_reg == '0) ? '0 : rem_reg;
            out_hash_reg   <= work_reg;
        end
    end

    assign hash_out.valid      = out_valid_reg;
    assign hash_out.bucket     = out_bucket_reg;
    assign hash_out.hash_value = out_hash_reg;

    // Checks
    `FKP_ASSERT_NEXT(a_end_starts_div, in_acc && key_in.key_end, state_reg == ST_DIV, "end word did not start the divider")
    `FKP_ASSERT_NEXT(a_end_resets_hash, in_acc && key_in.key_end, hash_reg == FNV_BASIS, "hash not back at basis after key end")
    `FKP_ASSERT_NOW(a_rem_bound, (state_reg != ST_IDLE) && (bcount_reg != '0), rem_reg < bcount_reg, "remainder not below divisor")
    `FKP_ASSERT_NOW(a_bucket_bound, hash_out.valid && (bcount_reg != '0), hash_out.bucket < bcount_reg, "bucket out of range")
    `FKP_ASSERT_NEXT(a_no_spurious_out, (state_reg == ST_IDLE) && !hash_out.valid, !hash_out.valid, "result appeared without a finished key")

endmodule

FILE: tb/sv/fnv1a_key_partitioner_top_tb.sv
// Self-checking testbench for fnv1a_key_partitioner_top: predicts the FNV-1a hash
// and bucket of every key (or takes them from a directed row) and compares each result word in order.
// Depends on fkp_pkg, fkp_if.sv and the RTL of fnv1a_key_partitioner_top.
`timescale 1ns / 100ps

module fnv1a_key_partitioner_top_tb;
    import fkp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 6;
    localparam int SETTLE_CYCLES = 70;    // key-end divider run plus margin
    localparam int LIMIT_CYCLES  = 600_000;
    localparam int RANDOM_WORDS  = 950;
    localparam int NUM_PHASES    = 9;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLDOFF_LEN   = 300;
    localparam int NUM_ROWS      = 20;

    localparam hash_t OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam hash_t HASH_PRIME   = 64'h0000_0100_0000_01b3;

    typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        byte_t     key_byte;
        logic      byte_present;
        logic      key_end;
        logic      typed;        // expected result written in the row
        bucket_t   cfg_value;
        bucket_t   exp_bucket;
        hash_t     exp_hash;
    } stim_row_t;

    typedef struct packed {
        bucket_t bucket;
        hash_t   hash_value;
    } key_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    bucket_t cfg_wr_data;

    fkp_in_if  key_in ();
    fkp_out_if hash_out ();

    fnv1a_key_partitioner_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_in      (key_in),
        .hash_out    (hash_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state and the queue of pending key results
    hash_t       key_hash;
    bucket_t     part_count;
    key_result_t pending_keys [$];
    int          mismatches = 0;

    // Sender pacing
    int burst_left   = 0;
    bit sender_eager = 1'b0;
    int phase_words  = 0;

    // Receiver pacing
    int holdoff_req  = 0;
    int holdoff_left = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int rx_cycle     = 0;

    // Directed words: extremes, empty keys, ignored words, bucket count extremes
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0,     16'd0, OFFSET_BASIS},
        '{ROW_WORD, 8'h3c, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h00, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'hff, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h00, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h80, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h61, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'ha5, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h5a, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'hff, 1'b0, 1'b1, 1'b1, 16'd0,     16'd0, OFFSET_BASIS},
        '{ROW_WORD, 8'h01, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, 16'd65535, 16'd0, 64'd0},
        '{ROW_WORD, 8'hff, 1'b1, 1'b0, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'hff, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, 16'd2,     16'd0, 64'd0},
        '{ROW_WORD, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0,     16'd1, OFFSET_BASIS},
        '{ROW_WORD, 8'h55, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0},
        '{ROW_WORD, 8'haa, 1'b1, 1'b1, 1'b0, 16'd0,     16'd0, 64'd0}
    };

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // One FNV-1a step: xor, then multiply by the prime (wraps at 64 bits)
    function automatic hash_t hash_fold_byte(input hash_t h, input byte_t b);
        return (h ^ hash_t'(b)) * HASH_PRIME;
    endfunction

    // Offer one word, wait for it to be taken, then advance the predictor
    task automatic push_word(input byte_t b, input logic present, input logic last,
                             input logic typed, input bucket_t typed_bucket,
                             input hash_t typed_hash);
        int          gap;
        key_result_t res;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!sender_eager && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0)
        begin
            key_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_in.valid        <= 1'b1;
        key_in.key_byte     <= b;
        key_in.byte_present <= present;
        key_in.key_end      <= last;
        do
            @(posedge clk);
        while (!key_in.ready);

        if (present || last)
            phase_words++;
        if (present)
            key_hash = hash_fold_byte(key_hash, b);
        if (last)
        begin
            res.hash_value = key_hash;
            res.bucket     = (part_count == 16'd0) ? 16'd0
                           : bucket_t'(key_hash % hash_t'(part_count));
            if (typed)
            begin
                res.bucket     = typed_bucket;
                res.hash_value = typed_hash;
            end
            pending_keys.push_back(res);
            key_hash = OFFSET_BASIS;
        end
    endtask

    // Drop valid, wait for all results, then let the bench settle
    task automatic wait_idle();
        key_in.valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bucket_count(input bucket_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        part_count = value;
    endtask

    // One key of random length and content, with some ignored words mixed in
    task automatic send_random_key();
        int len;
        int pick;
        bit split_end;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 8);
        else if (pick < 96)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 64);
        split_end = ($urandom_range(0, 4) == 0);

        if (len == 0)
            push_word(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0, '0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_word(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0, '0);
            push_word(byte_t'($urandom_range(0, 255)), 1'b1,
                      (i == len - 1) && !split_end, 1'b0, '0, '0);
        end
        // end mark on a word of its own
        if (len != 0 && split_end)
            push_word(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0, '0);
    endtask

    // Receiver: long hold-off on request, else a changing stall pattern
    always @(posedge clk)
    begin
        rx_cycle++;
        if (!rst_n)
            hash_out.ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            hash_out.ready <= 1'b0;
        end
        else if (holdoff_req > 0)
        begin
            holdoff_left = holdoff_req - 1;
            holdoff_req  = 0;
            hash_out.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       hash_out.ready <= 1'b1;
                1:       hash_out.ready <= ($urandom_range(0, 3) != 0);
                2:       hash_out.ready <= ($urandom_range(0, 1) != 0);
                default: hash_out.ready <= (rx_cycle[2:0] < 3'd3);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && hash_out.valid && hash_out.ready)
        begin
            if (pending_keys.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result word: bucket=%0d hash=%h",
                             hash_out.bucket, hash_out.hash_value);
                mismatches++;
            end
            else
            begin
                want = pending_keys.pop_front();
                if (hash_out.bucket !== want.bucket
                    || hash_out.hash_value !== want.hash_value)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: bucket exp %0d got %0d, hash exp %h got %h",
                                 want.bucket, hash_out.bucket,
                                 want.hash_value, hash_out.hash_value);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        bucket_t phase_counts [NUM_PHASES];
        int      phase_budget;
        rst_n               = 1'b0;
        key_in.valid        = 1'b0;
        key_in.key_byte     = '0;
        key_in.byte_present = 1'b0;
        key_in.key_end      = 1'b0;
        hash_out.ready      = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = 16'd1;
        key_hash            = OFFSET_BASIS;
        part_count          = 16'd1;
        phase_budget        = RANDOM_WORDS / NUM_PHASES;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_bucket_count(directed_rows[r].cfg_value);
            end
            else
                push_word(directed_rows[r].key_byte, directed_rows[r].byte_present,
                          directed_rows[r].key_end, directed_rows[r].typed,
                          directed_rows[r].exp_bucket, directed_rows[r].exp_hash);
        end

        // random keys, one bucket count per phase
        phase_counts = '{16'd65535, 16'd0, 16'd1, 16'd3, 16'd256,
                         bucket_t'($urandom_range(4, 255)), 16'd65534,
                         bucket_t'($urandom_range(257, 65533)), 16'd1000};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_bucket_count(phase_counts[p]);
            // receiver backs up while the sender keeps pushing
            if (p == 1 || p == 5)
            begin
                holdoff_req  = HOLDOFF_LEN;
                sender_eager = 1'b1;
            end
            else
                sender_eager = ($urandom_range(0, 3) == 0);
            phase_words = 0;
            while (phase_words < phase_budget)
                send_random_key();
        end

        wait_idle();
        if (mismatches == 0 && pending_keys.size() == 0)
            $display("fnv1a_key_partitioner_top_tb: PASS");
        else
            $display("fnv1a_key_partitioner_top_tb: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("fnv1a_key_partitioner_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: fnv1a_key_partitioner_top.f
+incdir+hw/rtl
hw/rtl/fkp_pkg.sv
hw/rtl/fkp_if.sv
hw/rtl/fnv1a_key_partitioner_top.sv
tb/sv/fnv1a_key_partitioner_top_tb.sv
